// ----- src/tmac_pkg.sv -----
// Shared constants for the triangle minimum-angle check.
// No dependencies; imported by triangle_min_angle_check, its checker and its testbench.
package tmac_pkg;

    // Cosine limit register: signed Q1.15.
    localparam int LIMIT_W = 16;
    localparam int FRAC_BITS = 15;
    localparam logic signed [LIMIT_W-1:0] LIMIT_RESET = 16'sd28378;

    // Result item: one flag padded to a byte.
    localparam int OUT_TDATA_W = 8;

    // Angle index, named by the side opposite the angle.
    localparam int ANGLE_A = 0;
    localparam int ANGLE_B = 1;
    localparam int ANGLE_C = 2;
    localparam int NUM_ANGLES = 3;

endpackage

// ----- src/triangle_min_angle_check.sv -----
// Triangle minimum-angle check: triangle inequality plus law-of-cosines limit per angle.
// Depends on tmac_pkg (limit width, reset value, result width, angle indexes).
//
//   Channel  | Direction | Handshake              | Payload
//   ---------+-----------+------------------------+------------------------------------------
//   s (in)   | input     | i_s_tvalid/o_s_tready  | i_s_tdata: side_a, side_b, side_c
//   m (out)  | output    | o_m_tvalid/i_m_tready  | o_m_tdata: valid_res in bit 0
//   cfg      | input     | i_cfg_wen              | i_cfg_wdata: cosine_limit, Q1.15 signed
//
// One item per cycle sustained while the output is not stalled.
// The five register stages are set by the square/product multipliers, the
// limit partial products and the wide compare of the law-of-cosines test.
// Reset (i_rst_n low, synchronous) empties the pipeline and loads cos 30 deg.
// A stalled output holds the whole pipeline in place; o_s_tready falls with it.

module triangle_min_angle_check #(
    parameter int SIDE_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_wen,
    input  logic [tmac_pkg::LIMIT_W-1:0]       i_cfg_wdata,
    // input items
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // side_a [SIDE_BITS-1:0], side_b next, side_c next, zero fill to bytes
    input  logic [((3*SIDE_BITS+7)/8)*8-1:0]   i_s_tdata,
    // result items
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // valid_res [0], zero fill [7:1]
    output logic [tmac_pkg::OUT_TDATA_W-1:0]   o_m_tdata
);
    import tmac_pkg::*;

    localparam int SB  = SIDE_BITS;
    localparam int SQW = 2 * SB;             // square / product width
    localparam int NW  = SQW + 2;            // signed p^2 + q^2 - r^2
    localparam int PPW = SB + LIMIT_W + 1;   // half product times limit
    localparam int CW  = SQW + LIMIT_W + 2;  // compare width for both sides

    // Cosine limit register.
    logic signed [LIMIT_W-1:0] r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_wen) begin
            r_limit <= signed'(i_cfg_wdata);
        end
    end

    // Whole pipeline advances together when the output slot is free or taken.
    logic advance;
    assign advance    = !o_m_tvalid || i_m_tready;
    assign o_s_tready = advance;

    // Valid bits per stage.
    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (advance) begin
            r_v1 <= i_s_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // ---------------- stage 1: unpack sides, strict triangle inequality
    logic [SB-1:0] in_a, in_b, in_c;
    logic [SB:0]   sum_ab, sum_bc, sum_ac;
    logic          n_tri;

    assign in_a = i_s_tdata[SB-1:0];
    assign in_b = i_s_tdata[2*SB-1:SB];
    assign in_c = i_s_tdata[3*SB-1:2*SB];

    always_comb begin
        sum_ab = {1'b0, in_a} + {1'b0, in_b};
        sum_bc = {1'b0, in_b} + {1'b0, in_c};
        sum_ac = {1'b0, in_a} + {1'b0, in_c};
        n_tri  = (sum_ab > {1'b0, in_c}) && (sum_bc > {1'b0, in_a})
              && (sum_ac > {1'b0, in_b});
    end

    logic [SB-1:0] r_a1, r_b1, r_c1;
    logic          r_tri1;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_a1   <= in_a;
            r_b1   <= in_b;
            r_c1   <= in_c;
            r_tri1 <= n_tri;
        end
    end

    // ---------------- stage 2: squares and pair products
    // For angle k: r is the opposite side, pq the product of the other two.
    logic [SQW-1:0] n_sq [NUM_ANGLES];
    logic [SQW-1:0] n_pq [NUM_ANGLES];

    always_comb begin
        n_sq[ANGLE_A] = SQW'(r_a1) * SQW'(r_a1);
        n_sq[ANGLE_B] = SQW'(r_b1) * SQW'(r_b1);
        n_sq[ANGLE_C] = SQW'(r_c1) * SQW'(r_c1);
        n_pq[ANGLE_A] = SQW'(r_b1) * SQW'(r_c1);
        n_pq[ANGLE_B] = SQW'(r_a1) * SQW'(r_c1);
        n_pq[ANGLE_C] = SQW'(r_a1) * SQW'(r_b1);
    end

    logic [SQW-1:0] r_sq2 [NUM_ANGLES];
    logic [SQW-1:0] r_pq2 [NUM_ANGLES];
    logic           r_tri2;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_sq2  <= n_sq;
            r_pq2  <= n_pq;
            r_tri2 <= r_tri1;
        end
    end

    // ---------------- stage 3: cosine numerators, limit partial products
    logic signed [NW-1:0]  n_num   [NUM_ANGLES];
    logic signed [PPW-1:0] n_pp_lo [NUM_ANGLES];
    logic signed [PPW-1:0] n_pp_hi [NUM_ANGLES];
    logic signed [SB:0]    half_lo [NUM_ANGLES];
    logic signed [SB:0]    half_hi [NUM_ANGLES];

    always_comb begin
        n_num[ANGLE_A] = signed'({2'b00, r_sq2[ANGLE_B]}) + signed'({2'b00, r_sq2[ANGLE_C]})
                       - signed'({2'b00, r_sq2[ANGLE_A]});
        n_num[ANGLE_B] = signed'({2'b00, r_sq2[ANGLE_A]}) + signed'({2'b00, r_sq2[ANGLE_C]})
                       - signed'({2'b00, r_sq2[ANGLE_B]});
        n_num[ANGLE_C] = signed'({2'b00, r_sq2[ANGLE_A]}) + signed'({2'b00, r_sq2[ANGLE_B]})
                       - signed'({2'b00, r_sq2[ANGLE_C]});
        for (int k = 0; k < NUM_ANGLES; k++) begin
            half_lo[k] = signed'({1'b0, r_pq2[k][SB-1:0]});
            half_hi[k] = signed'({1'b0, r_pq2[k][SQW-1:SB]});
            n_pp_lo[k] = PPW'(half_lo[k]) * PPW'(r_limit);
            n_pp_hi[k] = PPW'(half_hi[k]) * PPW'(r_limit);
        end
    end

    logic signed [NW-1:0]  r_num3   [NUM_ANGLES];
    logic signed [PPW-1:0] r_pp_lo3 [NUM_ANGLES];
    logic signed [PPW-1:0] r_pp_hi3 [NUM_ANGLES];
    logic                  r_tri3;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_num3   <= n_num;
            r_pp_lo3 <= n_pp_lo;
            r_pp_hi3 <= n_pp_hi;
            r_tri3   <= r_tri2;
        end
    end

    // ---------------- stage 4: scale both sides of the compare
    // lhs = 2^15 * num, rhs = 2 * limit * pq.
    logic signed [CW-1:0] n_lhs [NUM_ANGLES];
    logic signed [CW-1:0] n_rhs [NUM_ANGLES];

    always_comb begin
        for (int k = 0; k < NUM_ANGLES; k++) begin
            n_lhs[k] = CW'(r_num3[k]) <<< FRAC_BITS;
            n_rhs[k] = ((CW'(r_pp_hi3[k]) <<< SB) + CW'(r_pp_lo3[k])) <<< 1;
        end
    end

    logic signed [CW-1:0] r_lhs4 [NUM_ANGLES];
    logic signed [CW-1:0] r_rhs4 [NUM_ANGLES];
    logic                 r_tri4;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_lhs4 <= n_lhs;
            r_rhs4 <= n_rhs;
            r_tri4 <= r_tri3;
        end
    end

    // ---------------- stage 5: compare, output register
    // An angle at exactly the limit passes.
    logic n_ok;

    always_comb begin
        n_ok = r_tri4;
        for (int k = 0; k < NUM_ANGLES; k++) begin
            if (r_lhs4[k] > r_rhs4[k]) begin
                n_ok = 1'b0;
            end
        end
    end

    logic r_ok5;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_ok5 <= n_ok;
        end
    end

    assign o_m_tvalid = r_v5;
    assign o_m_tdata  = {{(OUT_TDATA_W-1){1'b0}}, r_ok5};

endmodule

// ----- verif/triangle_min_angle_check_checker.sv -----
// Checker for triangle_min_angle_check: watches the config, side and result channels,
// predicts each verdict and compares it. Depends on tmac_pkg for widths and reset limit.
module triangle_min_angle_check_checker #(
    parameter int SIDE_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wen,
    input  logic [tmac_pkg::LIMIT_W-1:0]       i_cfg_wdata,
    input  logic                               i_s_tvalid,
    input  logic                               i_s_tready,
    input  logic [((3*SIDE_BITS+7)/8)*8-1:0]   i_s_tdata,
    input  logic                               i_m_tvalid,
    input  logic                               i_m_tready,
    input  logic [tmac_pkg::OUT_TDATA_W-1:0]   i_m_tdata,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import tmac_pkg::*;

    logic signed [LIMIT_W-1:0] cos_limit;
    bit                        verdict_q[$];
    int                        fail_count;
    int                        pending;

    // One angle passes when 32768*(p^2 + q^2 - r^2) <= limit*2*p*q, r opposite the angle.
    function automatic bit angle_in_limit(input logic [SIDE_BITS-1:0] p,
                                          input logic [SIDE_BITS-1:0] q,
                                          input logic [SIDE_BITS-1:0] r,
                                          input logic signed [LIMIT_W-1:0] lim);
        longint pl, ql, rl, lv, lhs, rhs;
        pl = longint'(p);
        ql = longint'(q);
        rl = longint'(r);
        lv = longint'(lim);
        lhs = (pl * pl + ql * ql - rl * rl) * (longint'(1) << FRAC_BITS);
        rhs = lv * 2 * pl * ql;
        return !(lhs > rhs);
    endfunction

    function automatic bit triangle_accepted(input logic [SIDE_BITS-1:0] a,
                                             input logic [SIDE_BITS-1:0] b,
                                             input logic [SIDE_BITS-1:0] c,
                                             input logic signed [LIMIT_W-1:0] lim);
        longint al, bl, cl;
        al = longint'(a);
        bl = longint'(b);
        cl = longint'(c);
        if (!((al + bl > cl) && (bl + cl > al) && (al + cl > bl)))
            return 1'b0;
        return angle_in_limit(b, c, a, lim) && angle_in_limit(a, c, b, lim)
            && angle_in_limit(a, b, c, lim);
    endfunction

    always @(posedge i_clk) begin
        bit want;
        if (!i_rst_n) begin
            cos_limit = LIMIT_RESET;
            verdict_q.delete();
            fail_count = 0;
        end else begin
            // retire the result first so a stray one never meets its own item
            if (i_m_tvalid && i_m_tready) begin
                if (verdict_q.size() == 0) begin
                    $error("valid_res: expected none, actual %0d", i_m_tdata[0]);
                    fail_count++;
                end else begin
                    want = verdict_q.pop_front();
                    if (i_m_tdata[0] !== want) begin
                        $error("valid_res: expected %0d, actual %0d", want, i_m_tdata[0]);
                        fail_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                verdict_q.push_back(triangle_accepted(i_s_tdata[SIDE_BITS-1:0],
                                                      i_s_tdata[2*SIDE_BITS-1 -: SIDE_BITS],
                                                      i_s_tdata[3*SIDE_BITS-1 -: SIDE_BITS],
                                                      cos_limit));
            if (i_cfg_wen)
                cos_limit = i_cfg_wdata;
        end
        pending = verdict_q.size();
    end

    assign o_fail_count = fail_count;
    assign o_pending    = pending;

endmodule

// ----- verif/triangle_min_angle_check_tb.sv -----
// Testbench top for triangle_min_angle_check: drives side triples and limit writes,
// stalls both channels at random and reports the verdict from the checker's count.
// Depends on tmac_pkg, triangle_min_angle_check and triangle_min_angle_check_checker.
module triangle_min_angle_check_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tmac_pkg::*;

    localparam int SIDE_BITS  = 16;
    localparam int S_TDATA_W  = ((3*SIDE_BITS+7)/8)*8;
    localparam int SIDE_MAX   = (1 << SIDE_BITS) - 1;
    localparam int PIPE_LAT   = 5;
    localparam int RAND_ITEMS = 75;   // per limit setting, eight settings

    // limit settings used by the directed and random phases
    localparam logic signed [LIMIT_W-1:0] LIM_MAX  = 16'sh7FFF;
    localparam logic signed [LIMIT_W-1:0] LIM_MIN  = 16'sh8000;
    localparam logic signed [LIMIT_W-1:0] LIM_HALF = 16'sd16384;
    localparam logic signed [LIMIT_W-1:0] LIM_ZERO = 16'sd0;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_wen;
    logic [LIMIT_W-1:0]         i_cfg_wdata;
    logic                       i_s_tvalid;
    logic                       o_s_tready;
    logic [S_TDATA_W-1:0]       i_s_tdata;     // side_a [15:0], side_b [31:16], side_c [47:32]
    logic                       o_m_tvalid;
    logic                       i_m_tready;
    logic [OUT_TDATA_W-1:0]     o_m_tdata;     // valid_res [0], zero fill [7:1]

    int  chk_fails;
    int  chk_pending;
    bit  s_burst;
    bit  m_burst;

    triangle_min_angle_check #(
        .SIDE_BITS (SIDE_BITS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    triangle_min_angle_check_checker #(
        .SIDE_BITS (SIDE_BITS)
    ) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wen    (i_cfg_wen),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .o_fail_count (chk_fails),
        .o_pending    (chk_pending)
    );

    // 20 ns clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog: the slowest legal run is well under a millisecond.
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // Offer one triple. Idle first for a drawn number of cycles (none inside a
    // burst stretch), then hold tvalid and the data until the block takes the item.
    // Returns on the falling edge after the handshake with tvalid still high,
    // so back-to-back items never toggle tvalid within one step.
    task automatic send_sides(input logic [SIDE_BITS-1:0] a,
                              input logic [SIDE_BITS-1:0] b,
                              input logic [SIDE_BITS-1:0] c);
        int gap;
        if ($urandom_range(0, 15) == 0)
            s_burst = !s_burst;
        gap = s_burst ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tdata  <= {c, b, a};
        i_s_tvalid <= 1'b1;
        do
            @(posedge i_clk);
        while (!(i_s_tvalid && o_s_tready));
        @(negedge i_clk);
    endtask

    // Write the limit only with the pipeline drained: drop tvalid, wait until
    // every verdict is back, give the pipeline its latency, then pulse the write.
    task automatic write_limit(input logic signed [LIMIT_W-1:0] lim);
        i_s_tvalid <= 1'b0;
        while (chk_pending != 0)
            @(negedge i_clk);
        repeat (PIPE_LAT + 2) @(negedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= lim;
        @(negedge i_clk);
        i_cfg_wen   <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic int clamp_side(input int v);
        return (v < 0) ? 0 : (v > SIDE_MAX) ? SIDE_MAX : v;
    endfunction

    // Draw one random triple. Most are real triangles (general or close to
    // equilateral, so the angle test both passes and fails); the rest are
    // degenerate triples and raw noise across every bit.
    task automatic send_random_item();
        int mode, w, p, q, r, lo, hi, d, rot;
        int s[3];
        mode = $urandom_range(0, 9);
        if (mode <= 3) begin
            w  = $urandom_range(1, SIDE_BITS);
            p  = $urandom_range(1, (1 << w) - 1);
            q  = $urandom_range(1, (1 << w) - 1);
            lo = ((p > q) ? p - q : q - p) + 1;
            hi = (p + q - 1 > SIDE_MAX) ? SIDE_MAX : p + q - 1;
            r  = $urandom_range(lo, hi);
        end else if (mode <= 6) begin
            p = $urandom_range(1, SIDE_MAX);
            d = p / ($urandom_range(0, 1) ? 4 : 32) + 1;
            q = clamp_side(p + $urandom_range(0, 2 * d) - d);
            r = clamp_side(p + $urandom_range(0, 2 * d) - d);
        end else if (mode == 7) begin
            p = $urandom_range(0, SIDE_MAX);
            q = $urandom_range(0, SIDE_MAX - p);
            r = $urandom_range(0, 1) ? p + q : 0;
        end else begin
            p = $urandom_range(0, SIDE_MAX);
            q = $urandom_range(0, SIDE_MAX);
            r = $urandom_range(0, SIDE_MAX);
        end
        // rotate so every side position sees every role
        rot = $urandom_range(0, 2);
        s[rot] = p;
        s[(rot + 1) % 3] = q;
        s[(rot + 2) % 3] = r;
        send_sides(s[0][SIDE_BITS-1:0], s[1][SIDE_BITS-1:0], s[2][SIDE_BITS-1:0]);
    endtask

    // Result side: draw a stall per item, then hold tready until one is taken.
    initial begin
        int stall;
        i_m_tready = 1'b0;
        m_burst    = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 15) == 0)
                m_burst = !m_burst;
            stall = m_burst ? 0 : $urandom_range(0, 11);
            if (stall != 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            do
                @(posedge i_clk);
            while (!(o_m_tvalid && i_m_tready));
            @(negedge i_clk);
        end
    end

    // Main stimulus
    initial begin
        logic signed [LIMIT_W-1:0] lim_list[8];
        i_rst_n     = 1'b0;
        i_cfg_wen   = 1'b0;
        i_cfg_wdata = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        s_burst     = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed, reset limit (about cos 30 deg): zero, full-scale,
        // degenerate, thin and alternating-bit triples.
        send_sides(16'd0, 16'd0, 16'd0);
        send_sides(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_sides(16'd0, 16'hFFFF, 16'hFFFF);
        send_sides(16'hFFFF, 16'd0, 16'hFFFF);
        send_sides(16'd1, 16'd1, 16'd2);
        send_sides(16'hFFFF, 16'hFFFF, 16'd1);
        send_sides(16'd1, 16'd1, 16'd1);
        send_sides(16'd3, 16'd4, 16'd5);
        send_sides(16'hFFFF, 16'h8000, 16'h8000);
        send_sides(16'h5555, 16'hAAAA, 16'hAAAA);
        send_sides(16'hAAAA, 16'h5555, 16'h5555);
        send_sides(16'h8000, 16'hFFFF, 16'hFFFE);

        // Equilateral cosine sits exactly on a limit of one half: accept.
        write_limit(LIM_HALF);
        send_sides(16'd100, 16'd100, 16'd100);
        send_sides(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_sides(16'd3, 16'd4, 16'd5);

        // One step below: the same triangle must now be rejected.
        write_limit(LIM_HALF - 16'sd1);
        send_sides(16'd100, 16'd100, 16'd100);

        // Right angle exactly at a zero limit; the other two angles are too sharp.
        write_limit(LIM_ZERO);
        send_sides(16'd3, 16'd4, 16'd5);
        send_sides(16'd30000, 16'd40000, 16'd50000);

        // Extreme limits: widest and narrowest settings.
        write_limit(LIM_MAX);
        send_sides(16'hFFFF, 16'hFFFF, 16'd1);
        send_sides(16'd1, 16'd1, 16'd1);
        send_sides(16'd1, 16'd1, 16'd2);
        write_limit(LIM_MIN);
        send_sides(16'd1, 16'd1, 16'd1);
        send_sides(16'hFFFF, 16'hFFFF, 16'hFFFF);

        // Random phases, one per limit setting.
        lim_list[0] = LIMIT_RESET;
        lim_list[1] = LIM_MAX;
        lim_list[2] = LIM_MIN;
        lim_list[3] = LIM_HALF;
        lim_list[4] = LIM_ZERO;
        lim_list[5] = LIMIT_W'($urandom_range(0, 32767));
        lim_list[6] = LIMIT_W'($urandom_range(0, 65535));
        lim_list[7] = LIMIT_W'($urandom_range(16384, 32767));
        foreach (lim_list[k]) begin
            write_limit(lim_list[k]);
            repeat (RAND_ITEMS) send_random_item();
        end

        // Drain: drop tvalid, wait for the last verdict, then give any stray
        // result a chance to show up before the verdict.
        i_s_tvalid <= 1'b0;
        while (chk_pending != 0)
            @(negedge i_clk);
        repeat (4 * PIPE_LAT) @(posedge i_clk);
        if (chk_fails == 0 && chk_pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/tmac_pkg.sv
src/triangle_min_angle_check.sv
verif/triangle_min_angle_check_checker.sv
verif/triangle_min_angle_check_tb.sv
